// File: rtl/core/tdub_pkg.sv
// Shared types and constants for the tick divider with up-timer bank.
`default_nettype none
package tdub_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_CHECK = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Boundary pulses raised by one hardware tick.
  typedef struct packed {
    logic e2ms;
    logic e10ms;
    logic e100ms;
    logic e500ms;
    logic e1s;
  } tick_evt_t;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic [0:0]  REG_TICKS_PER_2MS = 1'b0;
  localparam logic [15:0] TICKS_RESET = 16'd20;
  localparam logic [31:0] MS_PER_BOUNDARY = 32'd2;

  localparam logic [2:0] DIV_10MS  = 3'd5;
  localparam logic [3:0] DIV_100MS = 4'd10;
  localparam logic [2:0] DIV_500MS = 3'd5;

endpackage
`default_nettype wire

// File: rtl/core/tdub_tick.sv
// Prescaler, boundary cascade and shared millisecond timestamp.
`default_nettype none
module tdub_tick
  import tdub_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        tick_en,
  input  wire logic [15:0] ticks_per_2ms,
  output tick_evt_t        evt,
  output logic [31:0]      now_ms
);

  logic [15:0] presc_r, presc_nxt, presc_inc;
  logic [2:0]  c2_r, c2_nxt, c2_inc;
  logic [3:0]  c10_r, c10_nxt, c10_inc;
  logic [2:0]  c100_r, c100_nxt, c100_inc;
  logic        c500_r, c500_nxt, c500_inc;
  logic [31:0] now_r, now_nxt;

  always_comb begin
    presc_inc = presc_r + 16'd1;
    c2_inc    = c2_r + 3'd1;
    c10_inc   = c10_r + 4'd1;
    c100_inc  = c100_r + 3'd1;
    c500_inc  = ~c500_r;

    presc_nxt = presc_r;
    c2_nxt    = c2_r;
    c10_nxt   = c10_r;
    c100_nxt  = c100_r;
    c500_nxt  = c500_r;
    now_nxt   = now_r;
    evt       = '0;

    if (tick_en) begin
      presc_nxt = presc_inc;
      if (presc_inc == ticks_per_2ms) begin
        presc_nxt = '0;
        evt.e2ms  = 1'b1;
        now_nxt   = now_r + MS_PER_BOUNDARY;
        c2_nxt    = c2_inc;
        if (c2_inc == DIV_10MS) begin
          c2_nxt     = '0;
          evt.e10ms  = 1'b1;
          c10_nxt    = c10_inc;
          if (c10_inc == DIV_100MS) begin
            c10_nxt    = '0;
            evt.e100ms = 1'b1;
            c100_nxt   = c100_inc;
            if (c100_inc == DIV_500MS) begin
              c100_nxt   = '0;
              evt.e500ms = 1'b1;
              c500_nxt   = c500_inc;
              // The second half-second boundary completes one second.
              if (!c500_inc) begin
                evt.e1s = 1'b1;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      presc_r <= '0;
      c2_r    <= '0;
      c10_r   <= '0;
      c100_r  <= '0;
      c500_r  <= 1'b0;
      now_r   <= '0;
    end else begin
      presc_r <= presc_nxt;
      c2_r    <= c2_nxt;
      c10_r   <= c10_nxt;
      c100_r  <= c100_nxt;
      c500_r  <= c500_nxt;
      now_r   <= now_nxt;
    end
  end

  assign now_ms = now_r;

endmodule
`default_nettype wire

// File: rtl/core/tdub_stamp.sv
// Start-timestamp memory with per-entry valid bits and write bypass.
`default_nettype none
module tdub_stamp #(
  parameter int unsigned NUM_TIMERS = 8,
  parameter int unsigned IDX_W = 3
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             rd_en,
  input  wire logic [IDX_W-1:0] rd_addr,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire logic [31:0]      wr_data,
  output logic [31:0]           stamp
);

  logic [31:0]           mem [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] vld_r;
  logic [31:0]           mem_q_r;
  logic                  vld_q_r;
  logic                  byp_r;
  logic [31:0]           byp_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= '0;
      vld_q_r    <= 1'b0;
      byp_r      <= 1'b0;
      byp_data_r <= '0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        vld_q_r    <= vld_r[rd_addr];
        // A start committing at the read edge is not yet in the array.
        byp_r      <= wr_en && (wr_addr == rd_addr);
        byp_data_r <= wr_data;
      end
    end
  end

  // A timer never started counts from reset, so its stamp reads as zero.
  assign stamp = byp_r ? byp_data_r : (vld_q_r ? mem_q_r : 32'd0);

endmodule
`default_nettype wire

// File: rtl/core/tick_divider_with_uptimer_bank_core.sv
// Top level of the tick divider with a bank of count-up timers.
//
//   Channel   Direction  Handshake             Payload
//   in_       input      in_valid/in_ready     op, timer_index, limit_ms
//   out_      output     out_valid/out_ready   elapsed_ms, timed_out, index_valid, events
//   cfg_      APB slave  psel/penable/pready   ticks_per_2ms at byte address 0
//
// One item is accepted per clock cycle while the output is not stalled. An
// accepted item is held in the input register, and its result is then
// registered in the output register.
// Reset (rst_n low, synchronous) empties both registers and clears the
// prescaler, the cascade and every timer; no clearing pass is needed.
// When the output is stalled, the input register holds and in_ready drops
// once that register is full.
//
// Timers are not counted one by one. A single millisecond timestamp gains
// 2 ms at every 2 ms boundary, and a start records that timestamp for its
// timer. The elapsed time of a timer is the difference between the current
// timestamp and its recorded start, which wraps modulo 2^32 exactly as a
// per-timer counter would. Start stamps live in a small memory read at the
// transfer edge; a start committing at that same edge is forwarded.
`default_nettype none
module tick_divider_with_uptimer_bank_core
  import tdub_pkg::*;
#(
  parameter int unsigned NUM_TIMERS = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,

  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [1:0]            in_op,
  input  wire logic [7:0]            in_timer_index,
  input  wire logic [31:0]           in_limit_ms,

  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [31:0]                out_elapsed_ms,
  output logic                       out_timed_out,
  output logic                       out_index_valid,
  output logic                       out_event_2ms,
  output logic                       out_event_10ms,
  output logic                       out_event_100ms,
  output logic                       out_event_500ms,
  output logic                       out_event_1s,

  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [31:0]           cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);

  localparam int unsigned IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  // Configuration register.
  logic [15:0] ticks_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                  && (cfg_paddr[2] == REG_TICKS_PER_2MS);
  assign cfg_prdata = (cfg_paddr[2] == REG_TICKS_PER_2MS) ? {16'd0, ticks_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r <= TICKS_RESET;
    end else if (cfg_wr) begin
      ticks_r <= cfg_pwdata[15:0];
    end
  end

  // Input register stage.
  logic        s1_v_r;
  op_t         op_r;
  logic [7:0]  idx_r;
  logic [31:0] timeout_r;
  logic        s1_adv;
  logic        in_xfer;
  logic        commit;
  logic        idx_ok;

  assign s1_adv   = !out_valid || out_ready;
  assign in_ready = !s1_v_r || s1_adv;
  assign in_xfer  = in_valid && in_ready;
  assign commit   = s1_v_r && s1_adv;
  // The compare is one bit wider than the index so that a full bank of 256 fits.
  assign idx_ok   = ({1'b0, idx_r} < 9'(NUM_TIMERS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r      <= op_t'(in_op);
      idx_r     <= in_timer_index;
      timeout_r <= in_limit_ms;
    end
  end

  // Prescaler and timestamp advance only when a tick commits.
  tick_evt_t   evt;
  logic [31:0] now_ms;

  tdub_tick u_tick (
    .clk           (clk),
    .rst_n         (rst_n),
    .tick_en       (commit && (op_r == OP_TICK)),
    .ticks_per_2ms (ticks_r),
    .evt           (evt),
    .now_ms        (now_ms)
  );

  logic [31:0] stamp;

  tdub_stamp #(
    .NUM_TIMERS (NUM_TIMERS),
    .IDX_W      (IDX_W)
  ) u_stamp (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_xfer),
    .rd_addr (in_timer_index[IDX_W-1:0]),
    .wr_en   (commit && (op_r == OP_START) && idx_ok),
    .wr_addr (idx_r[IDX_W-1:0]),
    .wr_data (now_ms),
    .stamp   (stamp)
  );

  // Result computation.
  logic [31:0] elapsed;
  logic [31:0] res_elapsed;
  logic        res_timed_out;
  logic        res_index_valid;
  tick_evt_t   res_evt;

  assign elapsed = now_ms - stamp;

  always_comb begin
    res_elapsed     = '0;
    res_timed_out   = 1'b0;
    res_index_valid = 1'b0;
    res_evt         = '0;
    case (op_r)
      OP_TICK: begin
        res_evt = evt;
      end
      OP_START: begin
        res_index_valid = idx_ok;
      end
      OP_CHECK: begin
        res_index_valid = idx_ok;
        if (idx_ok) begin
          res_elapsed   = elapsed;
          res_timed_out = (elapsed > timeout_r);
        end
      end
      default: begin
        res_index_valid = 1'b0;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_elapsed_ms  <= res_elapsed;
      out_timed_out   <= res_timed_out;
      out_index_valid <= res_index_valid;
      out_event_2ms   <= res_evt.e2ms;
      out_event_10ms  <= res_evt.e10ms;
      out_event_100ms <= res_evt.e100ms;
      out_event_500ms <= res_evt.e500ms;
      out_event_1s    <= res_evt.e1s;
    end
  end

`ifndef SYNTH
  // Each slower boundary can only fire together with the faster one below it.
  a_cascade: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((!out_event_10ms || out_event_2ms) &&
                   (!out_event_100ms || out_event_10ms) &&
                   (!out_event_500ms || out_event_100ms) &&
                   (!out_event_1s || out_event_500ms)))
    else $error("boundary cascade out of order");

  // A tick result never carries timer fields.
  a_tick_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_2ms) |-> (!out_index_valid && out_elapsed_ms == 32'd0))
    else $error("tick result carries timer fields");

  // A timeout is reported only for an in-range timer.
  a_timeout_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_timed_out) |-> out_index_valid)
    else $error("timeout on an invalid index");

  // The input side stalls only when both registers are full and the output waits.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_v_r && out_valid && !out_ready))
    else $error("input stalled without backpressure");
`endif

endmodule
`default_nettype wire
